/* hw/rtl/nla_pkg.sv */
// Package for the nearest landmark association block.
// Holds widths, the opcode and sequencer state types and the table entry layout.
// No dependencies.
package nla_pkg;

    localparam int ID_W             = 16;
    localparam int COORD_W          = 24;
    localparam int MAG_W            = COORD_W + 1;
    localparam int SQ_W             = 2 * MAG_W;
    localparam int SUM_W            = SQ_W + 1;
    localparam int DIST_W           = 52;
    localparam int MAX_LANDMARKS_DEF = 64;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_DX,
        S_DY,
        S_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
        logic [ID_W-1:0]           id;
    } entry_t;

endpackage

/* hw/rtl/nla_if.sv */
// Stream interfaces for observation input and association result output.
// Depends on nla_pkg.
interface nla_in_if;
    import nla_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic [ID_W-1:0]           landmark_id;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;

    modport source (output valid, output opcode, output landmark_id, output x_coord,
                    output y_coord, input ready);
    modport sink   (input valid, input opcode, input landmark_id, input x_coord,
                    input y_coord, output ready);
endinterface

interface nla_out_if;
    import nla_pkg::*;
    logic              valid;
    logic              ready;
    logic              match_found;
    logic [ID_W-1:0]   match_id;
    logic [DIST_W-1:0] min_distance_sq;

    modport source (output valid, output match_found, output match_id,
                    output min_distance_sq, input ready);
    modport sink   (input valid, input match_found, input match_id,
                    input min_distance_sq, output ready);
endinterface

/* hw/rtl/nla_table.sv */
// Landmark table memory: one write port, one registered read port.
// Depends on nla_pkg.
module nla_table #(
    parameter int DEPTH = nla_pkg::MAX_LANDMARKS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  nla_pkg::entry_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output nla_pkg::entry_t rd_data
);
    import nla_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/nla_sq_unit.sv */
// Shared squared-difference unit: (a - b)^2 with a registered product.
// Depends on nla_pkg.
module nla_sq_unit (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [nla_pkg::COORD_W-1:0] a,
    input  logic signed [nla_pkg::COORD_W-1:0] b,
    output logic [nla_pkg::SQ_W-1:0]           sq
);
    import nla_pkg::*;

    logic signed [MAG_W-1:0] diff;
    logic [MAG_W-1:0]        mag;
    logic [SQ_W-1:0]         sq_reg;

    always_comb
    begin
        diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        // magnitude fits MAG_W bits unsigned, including the most negative difference
        mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= mag * mag;
        end
    end

    assign sq = sq_reg;

endmodule

/* hw/rtl/nearest_landmark_association.sv */
// Top level of the nearest landmark association block: sequencer, table and
// shared squaring unit. Depends on nla_pkg, nla_if, nla_table, nla_sq_unit.
//
//  channel  | dir | payload                                   | transfer when
//  ---------+-----+-------------------------------------------+------------------
//  in_ch    | in  | opcode, landmark_id, x_coord, y_coord     | valid & ready
//  out_ch   | out | match_found, match_id, min_distance_sq    | valid & ready
//
// A query walks the stored entries through S_RD, S_DX, S_DY and S_CMP and
// ends in S_DONE, straight from S_IDLE on an empty table; every entry gets a
// table read, two passes through the one shared squaring multiplier and a
// compare step. Reset clears the entry count and the sequencer; table
// contents are left as they are. A query result waits in the output
// register while the next clear or load is taken; a following query stalls
// at its end until the previous result has been transferred.
module nearest_landmark_association #(
    parameter int MAX_LANDMARKS = nla_pkg::MAX_LANDMARKS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    nla_in_if.sink    in_ch,
    nla_out_if.source out_ch
);
    import nla_pkg::*;

    localparam int AW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int CW = $clog2(MAX_LANDMARKS + 1);

    // Control state
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic          best_found_reg, best_found_next;

    // Payload state
    logic signed [COORD_W-1:0] qx_reg, qy_reg;
    logic [SQ_W-1:0]           sq_x_reg;
    logic [ID_W-1:0]           best_id_reg, best_id_next;
    logic [SUM_W-1:0]          best_dist_reg, best_dist_next;
    logic                      res_found_reg;
    logic [ID_W-1:0]           res_id_reg;
    logic [SUM_W-1:0]          res_dist_reg;

    logic          in_xfer;
    logic          out_load;
    op_t           op;
    logic          wr_en;
    entry_t        wr_data;
    entry_t        rd_data;
    logic          sq_en;
    logic signed [COORD_W-1:0] sq_a, sq_b;
    logic [SQ_W-1:0]           sq;
    logic [SUM_W-1:0]          cand_dist;
    logic [CW-1:0]             idx_inc;

    assign op      = op_t'(in_ch.opcode);
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_xfer = in_ch.valid && in_ch.ready;
    assign wr_en   = in_xfer && (op == OP_LOAD) && (count_reg < CW'(MAX_LANDMARKS));
    assign wr_data = '{y: in_ch.y_coord, x: in_ch.x_coord, id: in_ch.landmark_id};
    assign cand_dist = SUM_W'(sq_x_reg) + SUM_W'(sq);
    assign idx_inc = idx_reg + 1'b1;

    nla_table #(
        .DEPTH (MAX_LANDMARKS),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // Squaring unit: x difference in S_DX, y difference in S_DY
    assign sq_en = (state_reg == S_DX) || (state_reg == S_DY);
    assign sq_a  = (state_reg == S_DX) ? qx_reg : qy_reg;
    assign sq_b  = (state_reg == S_DX) ? rd_data.x : rd_data.y;

    nla_sq_unit u_sq (
        .clk (clk),
        .en  (sq_en),
        .a   (sq_a),
        .b   (sq_b),
        .sq  (sq)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        best_found_next = best_found_reg;
        best_id_next    = best_id_reg;
        best_dist_next  = best_dist_reg;
        out_load        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_LOAD:
                        begin
                            if (wr_en)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            idx_next        = '0;
                            best_found_next = 1'b0;
                            best_id_next    = '0;
                            best_dist_next  = '0;
                            state_next      = (count_reg == '0) ? S_DONE : S_RD;
                        end
                        default:
                        begin
                            // unused opcode: drop
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_DX;
            end
            S_DX:
            begin
                state_next = S_DY;
            end
            S_DY:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // strict compare keeps the earliest entry on a tie
                if (!best_found_reg || (cand_dist < best_dist_reg))
                begin
                    best_found_next = 1'b1;
                    best_id_next    = rd_data.id;
                    best_dist_next  = cand_dist;
                end
                idx_next   = idx_inc;
                state_next = (idx_inc == count_reg) ? S_DONE : S_RD;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            best_found_reg <= best_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && (op == OP_QUERY))
        begin
            qx_reg <= in_ch.x_coord;
            qy_reg <= in_ch.y_coord;
        end
        if (state_reg == S_DY)
        begin
            sq_x_reg <= sq;
        end
        best_id_reg   <= best_id_next;
        best_dist_reg <= best_dist_next;
        if (out_load)
        begin
            res_found_reg <= best_found_reg;
            res_id_reg    <= best_id_reg;
            res_dist_reg  <= best_dist_reg;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.match_found     = res_found_reg;
    assign out_ch.match_id        = res_id_reg;
    assign out_ch.min_distance_sq = DIST_W'(res_dist_reg);

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LANDMARKS))
        else $error("entry count above table depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (idx_reg < count_reg))
        else $error("scan index past last entry");

    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_found_reg) |-> (res_id_reg == '0 && res_dist_reg == '0))
        else $error("no-match result carries nonzero fields");

    a_busy_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> $stable(count_reg))
        else $error("entry count changed during a query");

endmodule
